FILE: sv/sfd_pkg.sv
// sfd_pkg: shared types and constants for the sync frame deframer with repeat suppression
// no dependencies; imported by every module of the block
`default_nettype none

package sfd_pkg;

	localparam int unsigned FRAME_LEN       = 6;
	localparam int unsigned KEEP_LEN        = FRAME_LEN - 1;
	localparam int unsigned FILL_W          = 3;
	localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
	localparam logic [15:0] HOLD_OFF_RESET  = 16'd500;
	localparam int unsigned PADDR_W         = 3;
	localparam logic        REG_HOLD_OFF    = 1'b0;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] time_ms;
	} byte_item_t;

	typedef struct packed {
		logic [7:0]  hit_angle;
		logic [15:0] hit_range;
	} hit_item_t;

endpackage

`default_nettype wire

FILE: sv/sfd_frame.sv
// sfd_frame: byte window, sync pair check, frame decode and repeat suppression state
// depends on sfd_pkg
`default_nettype none

module sfd_frame (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire sfd_pkg::byte_item_t item,
	input  wire logic [15:0]        hold_off,
	output logic                    emit,
	output sfd_pkg::hit_item_t      hit
);
	import sfd_pkg::*;

	logic [7:0]        win_q [KEEP_LEN];
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        prev_angle_q;
	logic [15:0]       prev_range_q;
	logic [31:0]       prev_time_q;

	logic        full;
	logic        sync_ok;
	logic        frame;
	logic [31:0] delta;
	logic        repeat_hit;

	assign full    = (fill_q == FILL_W'(KEEP_LEN));
	assign sync_ok = (win_q[0] == SYNC_BYTE) && (win_q[1] == SYNC_BYTE);
	assign frame   = full && sync_ok;

	assign hit.hit_angle = win_q[2];
	assign hit.hit_range = {win_q[3], win_q[4]};

	assign delta      = item.time_ms - prev_time_q;
	assign repeat_hit = (hit.hit_angle == prev_angle_q) && (hit.hit_range == prev_range_q)
		&& (delta < {16'd0, hold_off});
	assign emit       = step && frame && !repeat_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			prev_angle_q <= '0;
			prev_range_q <= '0;
			prev_time_q  <= '0;
			for (int i = 0; i < KEEP_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (step) begin
			if (!full) begin
				for (int i = 0; i < KEEP_LEN; i++) begin
					if (fill_q == FILL_W'(i)) begin
						win_q[i] <= item.data_byte;
					end
				end
				fill_q <= fill_q + FILL_W'(1);
			end else if (!sync_ok) begin
				for (int i = 0; i < KEEP_LEN - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[KEEP_LEN-1] <= item.data_byte;
			end else begin
				fill_q <= '0;
			end
			if (emit) begin
				prev_angle_q <= hit.hit_angle;
				prev_range_q <= hit.hit_range;
				prev_time_q  <= item.time_ms;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/sync_frame_deframer_dedup.sv
// sync_frame_deframer_dedup: top level with input register, result register and apb port
// depends on sfd_pkg and sfd_frame
//
//  channel  | valid      | stall      | payload
//  ---------+------------+------------+----------------------------
//  byte in  | byte_valid | byte_stall | byte_data (data_byte, time_ms)
//  hit out  | hit_valid  | hit_stall  | hit_data (hit_angle, hit_range)
//  config   | psel/penable/pwrite, paddr, pwdata, prdata, pready
//
// one byte per cycle while byte_stall is low; a byte's hit is loaded into the result register
// the six-byte window check and suppression compare are combinational after the input register
// reset clears the window, the last-hit record and sets the hold-off to 500 ms
// byte_stall rises only while a hit waits in the result register and hit_stall is high
`default_nettype none

module sync_frame_deframer_dedup (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        byte_valid,
	output logic                             byte_stall,
	input  wire sfd_pkg::byte_item_t         byte_data,
	output logic                             hit_valid,
	input  wire logic                        hit_stall,
	output sfd_pkg::hit_item_t               hit_data,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sfd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import sfd_pkg::*;

	logic       item_valid_s1;
	byte_item_t item_s1;
	logic       advance;
	logic       emit;
	hit_item_t  hit;
	logic [15:0] hold_off_q;

	assign advance    = item_valid_s1 && (!hit_valid || !hit_stall);
	assign byte_stall = item_valid_s1 && !advance;
	assign pready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			item_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	sfd_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.hold_off (hold_off_q),
		.emit     (emit),
		.hit      (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid <= 1'b0;
		end else if (!hit_valid || !hit_stall) begin
			hit_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			hit_data <= hit;
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off_q <= HOLD_OFF_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HOLD_OFF)) begin
			hold_off_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_HOLD_OFF) ? {16'd0, hold_off_q} : 32'd0;

endmodule

`default_nettype wire

FILE: sv/sfd_checker.sv
// sfd_checker: port-level assertions for sync_frame_deframer_dedup and its bind
// depends on sfd_pkg and the top level's port list
`default_nettype none

module sfd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        byte_valid,
	input wire logic                        byte_stall,
	input wire logic                        hit_valid,
	input wire logic                        hit_stall,
	input wire sfd_pkg::hit_item_t          hit_data,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [sfd_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0]                 pwdata,
	input wire logic [31:0]                 prdata,
	input wire logic                        pready
);
	import sfd_pkg::*;

	// a waiting hit holds
	a_hit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_stall |=> hit_valid && $stable(hit_data))
		else $error("hit changed while stalled");

	// input backpressure only comes from a blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> hit_valid && hit_stall)
		else $error("byte stall without blocked hit");

	// a hit into an empty result register comes from a byte taken through the input register
	a_hit_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_valid) |-> $past(byte_valid && !byte_stall, 2))
		else $error("hit without a recent byte transaction");

	// a hold-off write reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr == '0)
		|=> (paddr != '0) || (prdata == {16'd0, $past(pwdata[15:0])}))
		else $error("hold-off readback mismatch");

endmodule

bind sync_frame_deframer_dedup sfd_checker u_sfd_checker (.*);

`default_nettype wire

FILE: verif/sync_frame_deframer_dedup_test.sv
// sync_frame_deframer_dedup_test: testbench for the sync frame deframer with repeat suppression
// predicts decoded hits for every byte transaction and checks each hit transaction in order
// depends on sfd_pkg and sync_frame_deframer_dedup
`timescale 1ns / 100ps

module sync_frame_deframer_dedup_test;

	import sfd_pkg::*;

	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned REPORT_MAX = 200;
	localparam int unsigned RANDOM_ITEMS = 385;
	localparam logic [PADDR_W-1:0] HOLD_OFF_ADDR = {REG_HOLD_OFF, 2'b00};
	localparam logic [PADDR_W-1:0] NO_REG_ADDR = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	byte_item_t byte_data = '0;
	logic hit_valid;
	logic hit_stall = 1'b0;
	hit_item_t hit_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sync_frame_deframer_dedup dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.hit_valid(hit_valid),
		.hit_stall(hit_stall),
		.hit_data(hit_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [7:0] win_bytes [FRAME_LEN];
	int unsigned win_fill = 0;
	logic [7:0] last_angle = '0;
	logic [15:0] last_range = '0;
	logic [31:0] last_send_ms = '0;
	logic [15:0] hold_ms = HOLD_OFF_RESET;

	byte_item_t pending_bytes [$];
	hit_item_t expected_hits [$];
	hit_item_t hit_want;
	int unsigned failures = 0;

	// stimulus generator state
	logic [31:0] cur_ms = '0;
	logic [7:0] gen_angle = '0;
	logic [15:0] gen_range = '0;

	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;

	task automatic deframe_byte(input byte_item_t item);
		logic [7:0] angle;
		logic [15:0] rng;
		logic [31:0] delta;
		if (win_fill >= FRAME_LEN)
			win_fill = KEEP_LEN;
		win_bytes[win_fill] = item.data_byte;
		win_fill++;
		if (win_fill < FRAME_LEN)
			return;
		if (win_bytes[0] != SYNC_BYTE || win_bytes[1] != SYNC_BYTE) begin
			for (int i = 0; i < KEEP_LEN; i++)
				win_bytes[i] = win_bytes[i + 1];
			win_bytes[KEEP_LEN] = '0;
			win_fill = KEEP_LEN;
			return;
		end
		angle = win_bytes[2];
		rng = {win_bytes[3], win_bytes[4]};
		foreach (win_bytes[i])
			win_bytes[i] = '0;
		win_fill = 0;
		delta = item.time_ms - last_send_ms;
		if (angle == last_angle && rng == last_range && delta < {16'h0000, hold_ms})
			return;
		last_angle = angle;
		last_range = rng;
		last_send_ms = item.time_ms;
		expected_hits.push_back('{hit_angle: angle, hit_range: rng});
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		failures++;
		if (failures <= REPORT_MAX)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				deframe_byte(byte_data);
			if (!byte_valid || !byte_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					byte_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					byte_data <= pending_bytes.pop_front();
					byte_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 64);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks hits and stalls in changing modes
	always @(posedge clk) begin
		if (arst_n && hit_valid && !hit_stall) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected hit", '0, {8'h00, hit_data});
			end else begin
				hit_want = expected_hits.pop_front();
				if (hit_data.hit_angle !== hit_want.hit_angle)
					report_mismatch("hit_angle", {24'h0, hit_want.hit_angle},
						{24'h0, hit_data.hit_angle});
				if (hit_data.hit_range !== hit_want.hit_range)
					report_mismatch("hit_range", {16'h0, hit_want.hit_range},
						{16'h0, hit_data.hit_range});
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: hit_stall <= 1'b0;
			1: hit_stall <= ($urandom_range(0, 3) == 0);
			2: hit_stall <= ($urandom_range(0, 3) != 0);
			default: hit_stall <= stall_left[3];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (hit_valid && !hit_stall) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == HOLD_OFF_ADDR)
			hold_ms = value[15:0];
	endtask

	task automatic queue_byte(input logic [7:0] value);
		pending_bytes.push_back('{data_byte: value, time_ms: cur_ms});
	endtask

	task automatic queue_frame(input logic [7:0] angle, input logic [15:0] rng,
			input logic [7:0] tail);
		queue_byte(SYNC_BYTE);
		queue_byte(SYNC_BYTE);
		queue_byte(angle);
		queue_byte(rng[15:8]);
		queue_byte(rng[7:0]);
		queue_byte(tail);
	endtask

	task automatic step_clock_ms();
		case ($urandom_range(0, 9))
			0: cur_ms += {16'h0000, hold_ms};
			1: cur_ms += {16'h0000, hold_ms} - 32'd1;
			2: cur_ms += $urandom;
			3: cur_ms += 32'd0;
			default: cur_ms += $urandom_range(0, 2 * hold_ms + 2);
		endcase
	endtask

	function automatic logic [7:0] noise_byte();
		return ($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255));
	endfunction

	// mostly well-formed frames with repeats, plus stray bytes and cut-off frames
	task automatic queue_random(input int unsigned n_items);
		int unsigned made;
		int unsigned cut_len;
		made = 0;
		while (made < n_items) begin
			step_clock_ms();
			case ($urandom_range(0, 19))
				0, 1: begin
					queue_byte(noise_byte());
					made++;
				end
				2, 3: begin
					cut_len = $urandom_range(1, 5);
					queue_byte(SYNC_BYTE);
					for (int i = 1; i < cut_len; i++)
						queue_byte(noise_byte());
					made += cut_len;
				end
				default: begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: ;
						4: gen_angle = 8'($urandom_range(0, 255));
						5: gen_range = 16'($urandom_range(0, 65535));
						6: begin
							gen_angle = '0;
							gen_range = '0;
						end
						default: begin
							gen_angle = 8'($urandom_range(0, 255));
							gen_range = 16'($urandom_range(0, 65535));
						end
					endcase
					queue_frame(gen_angle, gen_range, noise_byte());
					made += FRAME_LEN;
				end
			endcase
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || byte_valid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [15:0] hold_plan [5];
		hold_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 65534)), HOLD_OFF_RESET};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// zero hit right after reset falls inside the hold-off from time zero
		cur_ms = 32'd10;
		queue_frame(8'h00, 16'h0000, 8'h5A);
		// stray byte ahead of an all-ones frame forces one resync drop
		cur_ms = 32'hFFFF_FF80;
		queue_byte(8'h00);
		queue_frame(8'hFF, 16'hFFFF, 8'hFF);
		// identical hit across the timestamp wrap: suppressed, then exactly at the hold-off
		cur_ms = 32'hFFFF_FF80 + 32'd256;
		queue_frame(8'hFF, 16'hFFFF, 8'h00);
		cur_ms = 32'hFFFF_FF80 + {16'h0000, HOLD_OFF_RESET};
		queue_frame(8'hFF, 16'hFFFF, 8'h00);
		wait_drained();

		foreach (hold_plan[p]) begin
			apb_write(HOLD_OFF_ADDR, {16'($urandom), hold_plan[p]});
			if (p == 2)
				apb_write(NO_REG_ADDR, $urandom);
			queue_random(RANDOM_ITEMS);
			wait_drained();
		end

		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
